@@ sv/sign_force_oscillator_integrator_defines.svh @@
// Assertion macros shared by the sign-force oscillator integrator.
`ifndef SIGN_FORCE_OSCILLATOR_INTEGRATOR_DEFINES_SVH
`define SIGN_FORCE_OSCILLATOR_INTEGRATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SFOI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SFOI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sfoi_pkg.sv @@
// Shared widths, codes, control word types and saturation for the integrator.
package sfoi_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 31;
    localparam int DT_W      = 16;
    localparam int SUB_W     = 11;
    localparam int RUN_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int UPC_W     = 4;
    localparam int VSUM_W    = DATA_W + 2;
    localparam int PROD_W    = DATA_W + DT_W + 2;

    localparam logic             METHOD_RST   = 1'b0;
    localparam logic [ACC_W-1:0] ACCEL_RST    = ACC_W'(5242880);
    localparam logic [DATA_W-1:0] INIT_POS_RST = DATA_W'(65536);
    localparam logic [DATA_W-1:0] INIT_VEL_RST = '0;
    localparam logic [DT_W-1:0]  DT_RST       = DT_W'(655);
    localparam logic [SUB_W-1:0] SUBSTEPS_RST = SUB_W'(16);
    localparam logic [RUN_W-1:0] RUN_LEN_RST  = RUN_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD,
        CFG_ACCEL,
        CFG_INIT_POS,
        CFG_INIT_VEL,
        CFG_DT,
        CFG_SUBSTEPS,
        CFG_RUN_LENGTH
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_ACC,
        MUL_VEL,
        MUL_HALF_VEL
    } t_mul_sel;

    typedef enum logic [1:0] {
        V_NOP,
        V_EULER,
        V_HALF,
        V_MID
    } t_v_op;

    typedef enum logic [1:0] {
        S_NOP,
        S_FULL,
        S_HALF
    } t_s_op;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_acc;
        t_v_op    v_op;
        t_s_op    s_op;
    } t_ctrl;

    function automatic logic [DATA_W-1:0] sat_data(input logic [VSUM_W-1:0] x);
        logic [DATA_W-1:0] r;
        if (x[VSUM_W-1:DATA_W-1] == '0 || x[VSUM_W-1:DATA_W-1] == '1) begin
            r = x[DATA_W-1:0];
        end else if (x[VSUM_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ sv/sign_force_oscillator_integrator.sv @@
// Top level of the sign-force oscillator integrator.
//
//  Channel  Direction  Handshake                  Beat content
//  in       in         i_in_valid / o_in_ready    i_restart
//  out      out        o_out_valid / i_out_ready  o_position, o_run_end
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A sample is emitted in the cycle after its input beat is taken.
// The state then advances: setup states MULA and LDA, then E0-E2 per Euler substep or M0-M3
// per midpoint substep, all through one shared multiplier; the last sample of a run starts no substeps.
// Synchronous active-low reset loads the register defaults; no clearing pass follows.
// The input is taken only while the sequencer is idle and the output register is free.
`include "sign_force_oscillator_integrator_defines.svh"
module sign_force_oscillator_integrator import sfoi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_position,
    output logic                 o_run_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    logic              r_method;
    logic [ACC_W-1:0]  r_accel;
    logic [DATA_W-1:0] r_init_pos;
    logic [DATA_W-1:0] r_init_vel;
    logic [DT_W-1:0]   r_dt;
    logic [SUB_W-1:0]  r_substeps;
    logic [RUN_W-1:0]  r_run_length;

    logic [RUN_W-1:0]  r_sample_idx;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_position;
    logic              r_run_end;

    logic              seq_idle;
    t_ctrl             ctrl;
    logic [DATA_W-1:0] dp_position;
    logic              in_fire;
    logic [RUN_W-1:0]  idx_eff;
    logic              last;
    logic              dp_load;
    logic              seq_start;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = seq_idle && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign idx_eff     = i_restart ? '0 : r_sample_idx;
    assign last        = ({1'b0, idx_eff} + (RUN_W+1)'(1)) >= {1'b0, r_run_length};
    assign dp_load     = in_fire && (i_restart || last);
    assign seq_start   = in_fire && !last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method     <= METHOD_RST;
            r_accel      <= ACCEL_RST;
            r_init_pos   <= INIT_POS_RST;
            r_init_vel   <= INIT_VEL_RST;
            r_dt         <= DT_RST;
            r_substeps   <= SUBSTEPS_RST;
            r_run_length <= RUN_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_METHOD:     r_method     <= i_cfg_data[0];
                CFG_ACCEL:      r_accel      <= i_cfg_data[ACC_W-1:0];
                CFG_INIT_POS:   r_init_pos   <= i_cfg_data;
                CFG_INIT_VEL:   r_init_vel   <= i_cfg_data;
                CFG_DT:         r_dt         <= i_cfg_data[DT_W-1:0];
                CFG_SUBSTEPS:   r_substeps   <= i_cfg_data[SUB_W-1:0];
                CFG_RUN_LENGTH: r_run_length <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_idx <= '0;
            r_out_valid  <= 1'b0;
        end else if (in_fire) begin
            r_sample_idx <= last ? '0 : idx_eff + RUN_W'(1);
            r_out_valid  <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_position <= i_restart ? r_init_pos : dp_position;
            r_run_end  <= last;
        end
    end

    sfoi_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (seq_start),
        .i_method   (r_method),
        .i_substeps (r_substeps),
        .o_idle     (seq_idle),
        .o_ctrl     (ctrl)
    );

    sfoi_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_load     (dp_load),
        .i_init_pos (r_init_pos),
        .i_init_vel (r_init_vel),
        .i_accel    (r_accel),
        .i_dt       (r_dt),
        .o_position (dp_position)
    );

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_run_end   = r_run_end;

    `SFOI_ASSERT_NEXT(a_start_leaves_idle, seq_start, !seq_idle, "sequencer did not start")
    `SFOI_ASSERT_NEXT(a_run_end_clears_idx, in_fire && last, r_sample_idx == '0,
                      "sample index not cleared at run end")
    `SFOI_ASSERT_NEXT(a_idx_advances, in_fire && !last,
                      r_sample_idx == $past(idx_eff) + RUN_W'(1), "sample index did not advance")
    `SFOI_ASSERT_SAME(a_busy_blocks_input, !seq_idle, !in_fire,
                      "input beat taken while integrating")

endmodule

@@ sv/sfoi_sequencer.sv @@
// Microcode sequencer: step counter, control store and substep loop counter.
module sfoi_sequencer import sfoi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_method,
    input  logic [SUB_W-1:0] i_substeps,
    output logic             o_idle,
    output t_ctrl            o_ctrl
);

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        BR_WAIT,
        BR_NEXT,
        BR_DISPATCH,
        BR_LOOP,
        BR_HALT
    } t_branch;

    typedef struct packed {
        t_ctrl   ctrl;
        t_branch br;
        t_upc    target;
    } t_uword;

    localparam t_upc UA_WAIT = t_upc'(0);
    localparam t_upc UA_MULA = t_upc'(1);
    localparam t_upc UA_LDA  = t_upc'(2);
    localparam t_upc UA_E0   = t_upc'(3);
    localparam t_upc UA_E1   = t_upc'(4);
    localparam t_upc UA_E2   = t_upc'(5);
    localparam t_upc UA_M0   = t_upc'(6);
    localparam t_upc UA_M1   = t_upc'(7);
    localparam t_upc UA_M2   = t_upc'(8);
    localparam t_upc UA_M3   = t_upc'(9);

    localparam t_ctrl C_NOP = '{mul_en: 1'b0, mul_sel: MUL_ACC, ld_acc: 1'b0,
                                v_op: V_NOP, s_op: S_NOP};

    t_upc             r_upc;
    t_upc             n_upc;
    logic [SUB_W-1:0] r_cnt;
    logic [SUB_W-1:0] n_cnt;
    t_uword           word;

    always_comb begin
        word.ctrl   = C_NOP;
        word.br     = BR_HALT;
        word.target = UA_WAIT;
        unique case (r_upc)
            UA_WAIT: begin
                word.br = BR_WAIT;
            end
            UA_MULA: begin
                word.ctrl.mul_en  = 1'b1;
                word.ctrl.mul_sel = MUL_ACC;
                word.br           = BR_NEXT;
            end
            UA_LDA: begin
                word.ctrl.ld_acc = 1'b1;
                word.br          = BR_DISPATCH;
            end
            UA_E0: begin
                word.ctrl.v_op = V_EULER;
                word.br        = BR_NEXT;
            end
            UA_E1: begin
                word.ctrl.mul_en  = 1'b1;
                word.ctrl.mul_sel = MUL_VEL;
                word.br           = BR_NEXT;
            end
            UA_E2: begin
                word.ctrl.s_op = S_FULL;
                word.br        = BR_LOOP;
                word.target    = UA_E0;
            end
            UA_M0: begin
                word.ctrl.v_op = V_HALF;
                word.br        = BR_NEXT;
            end
            UA_M1: begin
                word.ctrl.mul_en  = 1'b1;
                word.ctrl.mul_sel = MUL_HALF_VEL;
                word.br           = BR_NEXT;
            end
            UA_M2: begin
                word.ctrl.s_op = S_HALF;
                word.br        = BR_NEXT;
            end
            UA_M3: begin
                word.ctrl.v_op = V_MID;
                word.ctrl.s_op = S_FULL;
                word.br        = BR_LOOP;
                word.target    = UA_M0;
            end
            default: begin
                word.br = BR_HALT;
            end
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        n_cnt = r_cnt;
        unique case (word.br)
            BR_WAIT: begin
                if (i_start) begin
                    n_upc = UA_MULA;
                end
            end
            BR_NEXT: begin
                n_upc = r_upc + t_upc'(1);
            end
            BR_DISPATCH: begin
                n_cnt = i_substeps;
                if (i_substeps == '0) begin
                    n_upc = UA_WAIT;
                end else if (i_method) begin
                    n_upc = UA_M0;
                end else begin
                    n_upc = UA_E0;
                end
            end
            BR_LOOP: begin
                if (r_cnt == SUB_W'(1)) begin
                    n_upc = UA_WAIT;
                end else begin
                    n_cnt = r_cnt - SUB_W'(1);
                    n_upc = word.target;
                end
            end
            default: begin
                n_upc = UA_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_WAIT;
            r_cnt <= '0;
        end else begin
            r_upc <= n_upc;
            r_cnt <= n_cnt;
        end
    end

    assign o_idle = (r_upc == UA_WAIT);
    assign o_ctrl = word.ctrl;

endmodule

@@ sv/sfoi_datapath.sv @@
// Datapath: position and velocity registers, shared multiplier and saturating adders.
module sfoi_datapath import sfoi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_load,
    input  logic [DATA_W-1:0] i_init_pos,
    input  logic [DATA_W-1:0] i_init_vel,
    input  logic [ACC_W-1:0]  i_accel,
    input  logic [DT_W-1:0]   i_dt,
    output logic [DATA_W-1:0] o_position
);

    logic [DATA_W-1:0]        r_s;
    logic [DATA_W-1:0]        r_v;
    logic [DATA_W-1:0]        r_vh;
    logic [DATA_W-1:0]        r_sh;
    logic [ACC_W-1:0]         r_adt;
    logic [ACC_W-2:0]         r_ahalf;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [DATA_W:0]   mul_a;
    logic signed [DT_W:0]     mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [DATA_W-1:0]        sgn_src;
    logic [ACC_W-1:0]         mag;
    logic signed [VSUM_W-1:0] mag_ext;
    logic signed [VSUM_W-1:0] delta;
    logic signed [VSUM_W-1:0] vsum;
    logic [DATA_W-1:0]        v_new;
    logic signed [PROD_W-1:0] shifted;
    logic signed [VSUM_W-1:0] psum;
    logic [DATA_W-1:0]        s_new;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_VEL:      mul_a = signed'({r_v[DATA_W-1], r_v});
            MUL_HALF_VEL: mul_a = signed'({r_vh[DATA_W-1], r_vh});
            default:      mul_a = signed'({2'b00, i_accel});
        endcase
    end

    assign mul_b = signed'({1'b0, i_dt});
    assign mul_p = mul_a * mul_b;

    always_comb begin
        sgn_src = (i_ctrl.v_op == V_MID) ? r_sh : r_s;
        mag     = (i_ctrl.v_op == V_HALF) ? {1'b0, r_ahalf} : r_adt;
        mag_ext = signed'({{(VSUM_W-ACC_W){1'b0}}, mag});
        if (sgn_src == '0) begin
            delta = '0;
        end else if (sgn_src[DATA_W-1]) begin
            delta = mag_ext;
        end else begin
            delta = -mag_ext;
        end
        vsum  = signed'({{2{r_v[DATA_W-1]}}, r_v}) + delta;
        v_new = sat_data(vsum);
    end

    always_comb begin
        shifted = (i_ctrl.s_op == S_HALF) ? (r_prod >>> (DT_W + 1)) : (r_prod >>> DT_W);
        psum    = signed'({{2{r_s[DATA_W-1]}}, r_s}) + shifted[VSUM_W-1:0];
        s_new   = sat_data(psum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= INIT_POS_RST;
            r_v <= INIT_VEL_RST;
        end else if (i_load) begin
            r_s <= i_init_pos;
            r_v <= i_init_vel;
        end else begin
            if (i_ctrl.s_op == S_FULL) begin
                r_s <= s_new;
            end
            if (i_ctrl.v_op == V_EULER || i_ctrl.v_op == V_MID) begin
                r_v <= v_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.ld_acc) begin
            r_adt   <= r_prod[DT_W+ACC_W-1:DT_W];
            r_ahalf <= r_prod[DT_W+ACC_W-1:DT_W+1];
        end
        if (i_ctrl.v_op == V_HALF) begin
            r_vh <= v_new;
        end
        if (i_ctrl.s_op == S_HALF) begin
            r_sh <= s_new;
        end
    end

    assign o_position = r_s;

endmodule
